/* hw/rtl/boundary_signature_successors_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef BOUNDARY_SIGNATURE_SUCCESSORS_CORE_DEFINES_SVH
`define BOUNDARY_SIGNATURE_SUCCESSORS_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BSS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bss: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define BSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bss: next-cycle check failed");

`endif

/* hw/rtl/bss_pkg.sv */
package bss_pkg;

    // Symbol codes, two bits each.
    localparam logic [1:0] SYM_A = 2'd0;
    localparam logic [1:0] SYM_B = 2'd1;
    localparam logic [1:0] SYM_O = 2'd2;
    localparam logic [1:0] SYM_X = 2'd3;

    localparam int MAX_SYMBOLS = 32;
    localparam int SIG_W       = 2 * MAX_SYMBOLS;
    localparam int POS_W       = $clog2(MAX_SYMBOLS);
    localparam logic [POS_W-1:0] W_RESET = POS_W'(7);
    localparam logic [POS_W-1:0] W_MIN   = POS_W'(2);

    // Successor shapes that the case table can ask for.
    typedef enum logic [3:0] {
        KIND_O_,
        KIND_AB_,
        KIND_A_B,
        KIND_XA_B,
        KIND_AX_,
        KIND_X_B,
        KIND_AX_B,
        KIND_XX_B_TA,
        KIND_A_X_TB,
        KIND_A_TB,
        KIND_XA_X_TB,
        KIND_XA_TB,
        KIND_X_X_TB1,
        KIND_XX_TAB,
        KIND_XX_X_TAB
    } kind_t;

    // The list of successors for one signature.
    typedef struct packed {
        logic [2:0]      n;
        kind_t [3:0]     k;
    } plan_t;

    // Controller to datapath.
    typedef struct packed {
        logic       load;
        logic       step1;
        logic       step2;
        logic       clr_idx;
        logic       emit;
        kind_t      kind;
        logic [1:0] number;
        logic       none;
        logic       last;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic       idx_last;
        logic [5:0] key;
        logic       split;
        logic       out_free;
    } status_t;

    // Case table keyed on the symbols at positions 0, w-1 and w, and on the split flag.
    function automatic plan_t plan_of(logic [5:0] key, logic split);
        plan_t p;
        p.n = 3'd0;
        p.k = {4{KIND_O_}};
        case (key)
            {SYM_X, SYM_X, SYM_X}, {SYM_X, SYM_X, SYM_O}:
            begin
                p.k[0] = KIND_O_; p.n = 3'd1;
            end
            {SYM_O, SYM_X, SYM_X}, {SYM_O, SYM_X, SYM_O}:
            begin
                p.k[0] = KIND_AB_; p.k[1] = KIND_O_; p.n = 3'd2;
            end
            {SYM_X, SYM_O, SYM_X}, {SYM_X, SYM_O, SYM_O}:
            begin
                p.k[0] = KIND_A_B; p.k[1] = KIND_O_; p.n = 3'd2;
            end
            {SYM_O, SYM_O, SYM_O}, {SYM_O, SYM_O, SYM_X}:
            begin
                p.k[0] = KIND_AB_; p.k[1] = KIND_A_B;
                p.k[2] = KIND_XA_B; p.k[3] = KIND_O_; p.n = 3'd4;
            end
            {SYM_A, SYM_X, SYM_X}, {SYM_A, SYM_X, SYM_O}:
            begin
                p.k[0] = KIND_AX_; p.k[1] = KIND_O_; p.n = 3'd2;
            end
            {SYM_A, SYM_O, SYM_O}, {SYM_A, SYM_O, SYM_X}:
            begin
                p.k[0] = KIND_AX_; p.k[1] = KIND_A_B;
                p.k[2] = KIND_O_; p.k[3] = KIND_XX_B_TA; p.n = 3'd4;
            end
            {SYM_X, SYM_B, SYM_X}, {SYM_X, SYM_B, SYM_O}:
            begin
                p.k[0] = KIND_O_; p.k[1] = KIND_A_X_TB; p.n = 3'd2;
            end
            {SYM_X, SYM_X, SYM_B}:
            begin
                p.k[0] = KIND_A_TB; p.n = 3'd1;
            end
            {SYM_X, SYM_B, SYM_B}:
            begin
                p.k[0] = KIND_A_TB; p.k[1] = KIND_X_X_TB1; p.n = 3'd2;
            end
            {SYM_O, SYM_B, SYM_O}, {SYM_O, SYM_B, SYM_X}:
            begin
                p.k[0] = KIND_AB_; p.k[1] = KIND_O_;
                p.k[2] = KIND_A_X_TB; p.k[3] = KIND_XA_X_TB; p.n = 3'd4;
            end
            {SYM_O, SYM_O, SYM_B}:
            begin
                p.k[0] = KIND_X_B; p.k[1] = KIND_A_TB; p.k[2] = KIND_XA_TB; p.n = 3'd3;
            end
            {SYM_O, SYM_B, SYM_B}:
            begin
                p.k[0] = KIND_A_TB; p.k[1] = KIND_XA_TB; p.k[2] = KIND_X_X_TB1;
                p.n = 3'd3;
            end
            {SYM_O, SYM_X, SYM_B}:
            begin
                p.k[0] = KIND_A_TB; p.k[1] = KIND_XA_TB; p.n = 3'd2;
            end
            {SYM_X, SYM_O, SYM_B}:
            begin
                p.k[0] = KIND_X_B; p.k[1] = KIND_A_TB; p.n = 3'd2;
            end
            {SYM_A, SYM_B, SYM_B}:
            begin
                p.k[0] = KIND_A_TB;
                if (split)
                begin
                    p.k[1] = KIND_XX_TAB; p.k[2] = KIND_X_X_TB1; p.n = 3'd3;
                end
                else
                begin
                    p.k[1] = KIND_X_X_TB1; p.n = 3'd2;
                end
            end
            {SYM_A, SYM_A, SYM_B}:
            begin
                p.k[0] = KIND_A_B; p.k[1] = KIND_XX_B_TA; p.n = 3'd2;
            end
            {SYM_A, SYM_B, SYM_X}:
            begin
                p.k[0] = KIND_AX_B; p.k[1] = KIND_O_; p.k[2] = KIND_A_X_TB;
                p.k[3] = KIND_XX_X_TAB;
                p.n = split ? 3'd4 : 3'd3;
            end
            {SYM_A, SYM_X, SYM_B}:
            begin
                p.k[0] = KIND_A_TB; p.k[1] = KIND_XX_TAB;
                p.n = split ? 3'd2 : 3'd1;
            end
            {SYM_X, SYM_A, SYM_B}:
            begin
                p.k[0] = KIND_A_B; p.n = 3'd1;
            end
            {SYM_A, SYM_B, SYM_O}:
            begin
                p.k[0] = KIND_AX_; p.k[1] = KIND_O_; p.k[2] = KIND_A_X_TB;
                p.k[3] = KIND_XX_X_TAB;
                p.n = split ? 3'd4 : 3'd3;
            end
            {SYM_A, SYM_O, SYM_B}:
            begin
                p.k[0] = KIND_XA_B; p.k[1] = KIND_A_TB; p.k[2] = KIND_XX_TAB;
                p.n = split ? 3'd3 : 3'd2;
            end
            {SYM_O, SYM_A, SYM_B}:
            begin
                p.k[0] = KIND_A_B; p.k[1] = KIND_XA_B; p.n = 3'd2;
            end
            default:
            begin
                p.n = 3'd0;
            end
        endcase
        return p;
    endfunction

endpackage

/* hw/rtl/bss_dp.sv */
module bss_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bss_pkg::POS_W-1:0]        cfg_wdata,
    input  logic [bss_pkg::SIG_W-1:0]        signature,
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic [bss_pkg::SIG_W-1:0]        successor,
    output logic [1:0]                       successor_number,
    output logic                             none_found,
    output logic                             last,
    input  bss_pkg::cmd_t                    cmd,
    output bss_pkg::status_t                 st
);

    localparam int PW = bss_pkg::POS_W;
    localparam int SW = bss_pkg::SIG_W;

    typedef enum logic [2:0] {
        SRC_S,
        SRC_TA,
        SRC_TB,
        SRC_TB1,
        SRC_TAB
    } src_t;

    logic [PW-1:0]       w_cfg_reg;
    logic [PW-1:0]       eff_w;
    logic [SW-1:0]       s_reg;
    logic [PW-1:0]       idx_reg;
    logic signed [6:0]   ca_reg, cb0_reg, cb1_reg, cab_reg;
    logic                ta_found_reg, tb_found_reg, tb1_found_reg, tab_found_reg;
    logic [PW-1:0]       ta_pos_reg, tb_pos_reg, tb1_pos_reg, tab_pos_reg;
    logic                out_valid_reg;
    logic [SW-1:0]       succ_reg;
    logic [1:0]          num_reg;
    logic                none_reg, last_reg;

    logic [PW-1:0]       bi;
    logic [1:0]          sym_f, sym_b, sym_tb;
    logic signed [6:0]   ca_dec, cb0_dec, cb1_dec, cab_dec;

    logic [SW-1:0]       src, shifted, full_mask, tail_clr, succ_next;
    logic [3:0]          head;
    logic                head2, has_tail;
    logic [1:0]          tail_sym;
    src_t                sel;

    function automatic logic [1:0] sym_at(logic [SW-1:0] s, logic [PW-1:0] p);
        return s[{p, 1'b0} +: 2];
    endfunction

    function automatic logic [SW-1:0] put(logic [SW-1:0] s, logic [PW-1:0] p,
                                          logic [1:0] v);
        logic [SW-1:0] r;
        r = s;
        r[{p, 1'b0} +: 2] = v;
        return r;
    endfunction

    // Effective last position never goes below two.
    assign eff_w = (w_cfg_reg < bss_pkg::W_MIN) ? bss_pkg::W_MIN : w_cfg_reg;

    // Symbols seen by the scans this cycle.
    assign bi      = eff_w - idx_reg;
    assign sym_f   = sym_at(s_reg, idx_reg);
    assign sym_b   = sym_at(s_reg, bi);
    assign sym_tb  = (tb_found_reg && idx_reg == tb_pos_reg) ? bss_pkg::SYM_B : sym_f;
    assign ca_dec  = ca_reg - 7'sd1;
    assign cb0_dec = cb0_reg - 7'sd1;
    assign cb1_dec = cb1_reg - 7'sd1;
    assign cab_dec = cab_reg - 7'sd1;

    // Status to the controller.
    assign st.idx_last = (idx_reg == eff_w);
    assign st.key      = {sym_at(s_reg, '0), sym_at(s_reg, eff_w - PW'(1)),
                          sym_at(s_reg, eff_w)};
    assign st.split    = tb_found_reg && (tb_pos_reg != '0);
    assign st.out_free = !out_valid_reg || !out_stall;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            w_cfg_reg <= bss_pkg::W_RESET;
        else if (cfg_we)
            w_cfg_reg <= cfg_wdata;
    end

    // Bracket scans, one symbol per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            s_reg         <= signature;
            ca_reg        <= '0;
            cb0_reg       <= '0;
            cb1_reg       <= -7'sd1;
            cab_reg       <= '0;
            ta_found_reg  <= 1'b0;
            tb_found_reg  <= 1'b0;
            tb1_found_reg <= 1'b0;
            tab_found_reg <= 1'b0;
        end
        if (cmd.step1)
        begin
            // Forward scan that turns the matched B into A.
            if (sym_f == bss_pkg::SYM_A)
                ca_reg <= ca_reg + 7'sd1;
            else if (sym_f == bss_pkg::SYM_B)
            begin
                ca_reg <= ca_dec;
                if (ca_dec == 7'sd0 && !ta_found_reg)
                begin
                    ta_found_reg <= 1'b1;
                    ta_pos_reg   <= idx_reg;
                end
            end
            // Backward scans that turn the matched A into B.
            if (sym_b == bss_pkg::SYM_B)
            begin
                cb0_reg <= cb0_reg + 7'sd1;
                cb1_reg <= cb1_reg + 7'sd1;
            end
            else if (sym_b == bss_pkg::SYM_A)
            begin
                cb0_reg <= cb0_dec;
                cb1_reg <= cb1_dec;
                if (cb0_dec == 7'sd0 && !tb_found_reg)
                begin
                    tb_found_reg <= 1'b1;
                    tb_pos_reg   <= bi;
                end
                if (cb1_dec == 7'sd0 && !tb1_found_reg)
                begin
                    tb1_found_reg <= 1'b1;
                    tb1_pos_reg   <= bi;
                end
            end
        end
        if (cmd.step2)
        begin
            // Forward scan over the B-rewritten copy.
            if (sym_tb == bss_pkg::SYM_A)
                cab_reg <= cab_reg + 7'sd1;
            else if (sym_tb == bss_pkg::SYM_B)
            begin
                cab_reg <= cab_dec;
                if (cab_dec == 7'sd0 && !tab_found_reg)
                begin
                    tab_found_reg <= 1'b1;
                    tab_pos_reg   <= idx_reg;
                end
            end
        end
    end

    // Scan position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (cmd.load || cmd.clr_idx)
            idx_reg <= '0;
        else if ((cmd.step1 || cmd.step2) && !st.idx_last)
            idx_reg <= idx_reg + PW'(1);
    end

    // Shape of each successor kind.
    always_comb
    begin
        head     = 4'b0000;
        head2    = 1'b0;
        has_tail = 1'b0;
        tail_sym = bss_pkg::SYM_B;
        sel      = SRC_S;
        case (cmd.kind)
            bss_pkg::KIND_O_:       begin head = 4'b0010; end
            bss_pkg::KIND_AB_:      begin head = 4'b0100; head2 = 1'b1; end
            bss_pkg::KIND_A_B:      begin head = 4'b0000; has_tail = 1'b1; end
            bss_pkg::KIND_XA_B:     begin head = 4'b0011; head2 = 1'b1; has_tail = 1'b1; end
            bss_pkg::KIND_AX_:      begin head = 4'b1100; head2 = 1'b1; end
            bss_pkg::KIND_X_B:      begin head = 4'b0011; has_tail = 1'b1; end
            bss_pkg::KIND_AX_B:     begin head = 4'b1100; head2 = 1'b1; has_tail = 1'b1; end
            bss_pkg::KIND_XX_B_TA:
            begin
                head = 4'b1111; head2 = 1'b1; has_tail = 1'b1; sel = SRC_TA;
            end
            bss_pkg::KIND_A_X_TB:
            begin
                has_tail = 1'b1; tail_sym = bss_pkg::SYM_X; sel = SRC_TB;
            end
            bss_pkg::KIND_A_TB:     begin sel = SRC_TB; end
            bss_pkg::KIND_XA_X_TB:
            begin
                head = 4'b0011; head2 = 1'b1; has_tail = 1'b1;
                tail_sym = bss_pkg::SYM_X; sel = SRC_TB;
            end
            bss_pkg::KIND_XA_TB:    begin head = 4'b0011; head2 = 1'b1; sel = SRC_TB; end
            bss_pkg::KIND_X_X_TB1:
            begin
                head = 4'b0011; has_tail = 1'b1; tail_sym = bss_pkg::SYM_X; sel = SRC_TB1;
            end
            bss_pkg::KIND_XX_TAB:   begin head = 4'b1111; head2 = 1'b1; sel = SRC_TAB; end
            bss_pkg::KIND_XX_X_TAB:
            begin
                head = 4'b1111; head2 = 1'b1; has_tail = 1'b1;
                tail_sym = bss_pkg::SYM_X; sel = SRC_TAB;
            end
            default:                begin head = 4'b0010; end
        endcase
    end

    // Source word with the requested bracket rewrites applied.
    always_comb
    begin
        src = s_reg;
        case (sel)
            SRC_TA:
                if (ta_found_reg) src = put(s_reg, ta_pos_reg, bss_pkg::SYM_A);
            SRC_TB:
                if (tb_found_reg) src = put(s_reg, tb_pos_reg, bss_pkg::SYM_B);
            SRC_TB1:
                if (tb1_found_reg) src = put(s_reg, tb1_pos_reg, bss_pkg::SYM_B);
            SRC_TAB:
            begin
                if (tb_found_reg) src = put(src, tb_pos_reg, bss_pkg::SYM_B);
                if (tab_found_reg) src = put(src, tab_pos_reg, bss_pkg::SYM_A);
            end
            default: src = s_reg;
        endcase
    end

    // Compose: head symbols, the source moved up one position, optional tail at w.
    assign full_mask = {SW{1'b1}} >> {PW'(bss_pkg::MAX_SYMBOLS - 1) - eff_w, 1'b0};
    assign tail_clr  = ~(SW'(3) << {eff_w, 1'b0});
    assign shifted   = (src << 2) & full_mask & (head2 ? ~SW'(15) : ~SW'(3));

    always_comb
    begin
        succ_next = shifted | SW'(head);
        if (has_tail)
            succ_next = (succ_next & tail_clr) | (SW'(tail_sym) << {eff_w, 1'b0});
        if (cmd.none)
            succ_next = '0;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            succ_reg <= succ_next;
            num_reg  <= cmd.number;
            none_reg <= cmd.none;
            last_reg <= cmd.last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign successor        = succ_reg;
    assign successor_number = num_reg;
    assign none_found       = none_reg;
    assign last             = last_reg;

endmodule

/* hw/rtl/bss_ctrl.sv */
module bss_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bss_pkg::status_t   st,
    output bss_pkg::cmd_t      cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN1 = 5'b00010,
        ST_SCAN2 = 5'b00100,
        ST_PLAN  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    bss_pkg::plan_t  plan_reg, plan_next;
    logic [1:0]      eidx_reg, eidx_next;
    logic            is_none, is_last;

    assign in_stall = (state_reg != ST_IDLE);
    assign is_none  = (plan_reg.n == 3'd0);
    assign is_last  = is_none || ({1'b0, eidx_reg} == plan_reg.n - 3'd1);

    // Sequencing: load, two scan passes, table lookup, then one result per slot.
    always_comb
    begin
        state_next = state_reg;
        plan_next  = plan_reg;
        eidx_next  = eidx_reg;
        cmd        = '0;
        cmd.kind   = plan_reg.k[eidx_reg];
        cmd.number = eidx_reg;
        cmd.none   = is_none;
        cmd.last   = is_last;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN1;
                end
            ST_SCAN1:
            begin
                cmd.step1 = 1'b1;
                if (st.idx_last)
                begin
                    cmd.clr_idx = 1'b1;
                    state_next  = ST_SCAN2;
                end
            end
            ST_SCAN2:
            begin
                cmd.step2 = 1'b1;
                if (st.idx_last)
                    state_next = ST_PLAN;
            end
            ST_PLAN:
            begin
                plan_next  = bss_pkg::plan_of(st.key, st.split);
                eidx_next  = 2'd0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
                if (st.out_free)
                begin
                    cmd.emit  = 1'b1;
                    eidx_next = eidx_reg + 2'd1;
                    if (is_last)
                        state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            eidx_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            eidx_reg  <= eidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg <= plan_next;
    end

endmodule

/* hw/rtl/boundary_signature_successors_core.sv */
// Boundary signature successor generator. One signature (w+1 two-bit symbols, w set by
// the configuration register, two at least) is taken at a time; its successors leave one per
// transaction with successor_number counting 0..3 and last marking the final one, or a
// single result with none_found set. An item is taken in from the idle state; the bracket
// scans then walk one symbol per cycle (a first pass finds all three matches on the input,
// a second pass scans the B-rewritten copy), the case table is read, and the results
// leave one per cycle when the output is not stalled. A new signature is taken once the
// last result has been loaded into the output register.
module boundary_signature_successors_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bss_pkg::POS_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bss_pkg::SIG_W-1:0]     signature,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bss_pkg::SIG_W-1:0]     successor,
    output logic [1:0]                    successor_number,
    output logic                          none_found,
    output logic                          last
);

    bss_pkg::cmd_t    cmd;
    bss_pkg::status_t st;

    // Sequencer.
    bss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // Scans, successor assembly and output register.
    bss_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .signature        (signature),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .successor        (successor),
        .successor_number (successor_number),
        .none_found       (none_found),
        .last             (last),
        .cmd              (cmd),
        .st               (st)
    );

endmodule

/* hw/rtl/bss_checker.sv */
`include "boundary_signature_successors_core_defines.svh"

module bss_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [bss_pkg::SIG_W-1:0]     successor,
    input logic [1:0]                    successor_number,
    input logic                          none_found,
    input logic                          last
);

    // An empty result is the only result of its run and carries no signature.
    `BSS_ASSERT_IMPLY(a_none_alone, out_valid && none_found,
        successor == '0 && last && successor_number == 2'd0)

    // No new signature is taken while a run still has results to deliver.
    `BSS_ASSERT_IMPLY(a_busy_mid_run, out_valid && !last, in_stall)

    // An accepted signature keeps the block busy with its scans.
    `BSS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // A stalled result transaction holds its payload.
    `BSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(successor) && $stable(successor_number))

endmodule

bind boundary_signature_successors_core bss_checker u_bss_checker (.*);
